>>> rtl/gasdf_pkg.sv
// Package for the gas reading deframer: item types, CRC-8 constants and
// byte position codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gasdf_pkg;

    localparam int ByteW = 8;
    localparam int WordW = 16;
    localparam int PosW  = 3;

    // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first
    localparam logic [ByteW-1:0] CrcInit = 8'hFF;
    localparam logic [ByteW-1:0] CrcPoly = 8'h31;
    localparam logic [ByteW-1:0] CrcTop  = 8'h80;

    typedef logic [PosW-1:0] pos_t;

    // Byte positions inside one six-byte frame
    localparam pos_t PosCo2Hi  = 3'd0;
    localparam pos_t PosCo2Lo  = 3'd1;
    localparam pos_t PosCo2Crc = 3'd2;
    localparam pos_t PosVocHi  = 3'd3;
    localparam pos_t PosVocLo  = 3'd4;
    localparam pos_t PosVocCrc = 3'd5;

    typedef struct packed {
        logic [ByteW-1:0] raw_byte;
        logic             frame_start;
    } byte_item_t;

    typedef struct packed {
        logic [WordW-1:0] co2_reading;
        logic [WordW-1:0] voc_reading;
        logic             co2_crc_ok;
        logic             voc_crc_ok;
        logic             readings_updated;
    } result_item_t;

endpackage

`default_nettype wire

>>> rtl/gasdf_if.sv
// Handshake channels of the gas reading deframer: byte input and result output.
// Depends on gasdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gasdf_byte_if;
    import gasdf_pkg::*;

    logic       valid;
    logic       ready;
    byte_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gasdf_result_if;
    import gasdf_pkg::*;

    logic         valid;
    logic         ready;
    result_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/gasdf_crc8.sv
// One-byte CRC-8 update, eight shift steps unrolled.
// Depends on gasdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gasdf_crc8
    import gasdf_pkg::*;
(
    input  wire logic [ByteW-1:0] crc_in,
    input  wire logic [ByteW-1:0] data,
    output logic      [ByteW-1:0] crc_out
);

    always_comb
    begin
        logic [ByteW-1:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < ByteW; k++)
        begin
            if ((c & CrcTop) != '0)
                c = (c << 1) ^ CrcPoly;
            else
                c = c << 1;
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

>>> rtl/gasdf_frame_core.sv
// Frame state of the deframer: byte count, running CRC, word assembly and
// held readings. Produces one result on the last byte of a frame.
// Depends on gasdf_pkg and gasdf_crc8.
`timescale 1ns / 1ps
`default_nettype none

module gasdf_frame_core
    import gasdf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire byte_item_t   item,
    output logic              result_valid,
    output result_item_t      result
);

    pos_t             pos_reg, pos_next, pos_eff;
    logic [ByteW-1:0] crc_reg, crc_next, crc_in, crc_upd;
    logic [WordW-1:0] word_reg, word_next;
    logic [WordW-1:0] pend_co2_reg, pend_co2_next;
    logic             pend_ok_reg, pend_ok_next;
    logic [WordW-1:0] held_co2_reg, held_co2_next;
    logic [WordW-1:0] held_voc_reg, held_voc_next;
    logic             crc_match, upd;

    gasdf_crc8 u_crc8 (
        .crc_in  (crc_in),
        .data    (item.raw_byte),
        .crc_out (crc_upd)
    );

    // start flag or an unused count value restarts at the first byte
    assign pos_eff   = (item.frame_start || pos_reg > PosVocCrc) ? PosCo2Hi : pos_reg;
    assign crc_in    = (pos_eff == PosCo2Hi || pos_eff == PosVocHi) ? CrcInit : crc_reg;
    assign crc_match = (crc_reg == item.raw_byte);
    assign upd       = pend_ok_reg && crc_match;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        word_next     = word_reg;
        pend_co2_next = pend_co2_reg;
        pend_ok_next  = pend_ok_reg;
        held_co2_next = held_co2_reg;
        held_voc_next = held_voc_reg;
        result_valid  = 1'b0;

        result.co2_reading      = upd ? pend_co2_reg : held_co2_reg;
        result.voc_reading      = upd ? word_reg : held_voc_reg;
        result.co2_crc_ok       = pend_ok_reg;
        result.voc_crc_ok       = crc_match;
        result.readings_updated = upd;

        if (step)
        begin
            case (pos_eff)
                PosCo2Hi, PosCo2Lo, PosVocHi, PosVocLo:
                begin
                    crc_next  = crc_upd;
                    word_next = {word_reg[ByteW-1:0], item.raw_byte};
                    pos_next  = pos_eff + pos_t'(1);
                end
                PosCo2Crc:
                begin
                    pend_co2_next = word_reg;
                    pend_ok_next  = crc_match;
                    crc_next      = CrcInit;
                    pos_next      = PosVocHi;
                end
                PosVocCrc:
                begin
                    held_co2_next = result.co2_reading;
                    held_voc_next = result.voc_reading;
                    crc_next      = CrcInit;
                    pos_next      = PosCo2Hi;
                    result_valid  = 1'b1;
                end
                default:
                begin
                    pos_next = PosCo2Hi;
                    crc_next = CrcInit;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= PosCo2Hi;
            crc_reg      <= CrcInit;
            word_reg     <= '0;
            pend_co2_reg <= '0;
            pend_ok_reg  <= 1'b0;
            held_co2_reg <= '0;
            held_voc_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            word_reg     <= word_next;
            pend_co2_reg <= pend_co2_next;
            pend_ok_reg  <= pend_ok_next;
            held_co2_reg <= held_co2_next;
            held_voc_reg <= held_voc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/crc_checked_gas_reading_deframer.sv
// Top level of the gas reading deframer: input register, frame core, result register.
// Depends on gasdf_pkg, gasdf_if, gasdf_frame_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes the six bytes of a gas sensor measurement frame, one item per byte:
// CO2-equivalent word, its CRC-8, volatile organics word, its CRC-8 (poly 0x31,
// init 0xFF, MSB first). frame_start restarts the byte count; without it the
// count wraps after six bytes. On the sixth byte one result item is emitted with
// the held readings and per-word CRC status; readings are replaced only when both
// CRCs match, and reset to zero. One byte is accepted every clock cycle unless the
// input is stalled; a byte passes through an input register and the CRC/frame
// logic, and a frame's result is held in the result register. The result register
// decouples the sides: input stalls only while a result waits and is not taken.
module crc_checked_gas_reading_deframer
    import gasdf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    gasdf_byte_if.sink     frame_bytes,
    gasdf_result_if.source results
);

    logic         in_valid_reg;
    byte_item_t   in_item_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    logic         out_free, step, core_valid;
    result_item_t core_result;

    assign out_free          = !out_valid_reg || results.ready;
    assign step              = in_valid_reg && out_free;
    assign frame_bytes.ready = !in_valid_reg || out_free;

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

    gasdf_frame_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_bytes.ready)
                in_valid_reg <= frame_bytes.valid;
            if (core_valid)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_bytes.ready && frame_bytes.valid)
            in_item_reg <= frame_bytes.payload;
        if (core_valid)
            out_item_reg <= core_result;
    end

endmodule

`default_nettype wire
